// ===== design/iba_pkg.sv =====
// iba_pkg: field widths, sequencer step codes, control word layout and the
// microcode table of the indexed block allocator
// no dependencies
package iba_pkg;

  // fixed field widths
  localparam int LFSR_W    = 16;
  localparam int TOTAL_W   = 8;
  localparam int BLK_W     = 7;
  localparam int REQ_W     = 5;
  localparam int SEED_W    = 16;
  localparam int STEP_BITS = 8;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  // configuration register indexes
  localparam logic CFG_TOTAL = 1'b0;
  localparam logic CFG_SEED  = 1'b1;

  // status codes of a result word
  localparam logic ST_ALLOCATED = 1'b0;
  localparam logic ST_REFUSED   = 1'b1;

  // sequencer step codes
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] PC_IDLE   = 3'd0;
  localparam logic [PC_W-1:0] PC_PICK   = 3'd1;
  localparam logic [PC_W-1:0] PC_MOD_HI = 3'd2;
  localparam logic [PC_W-1:0] PC_MOD_LO = 3'd3;
  localparam logic [PC_W-1:0] PC_CHECK  = 3'd4;
  localparam logic [PC_W-1:0] PC_REFUSE = 3'd5;

  // branch conditions
  localparam logic [2:0] C_NEXT  = 3'd0;  // fall through
  localparam logic [2:0] C_START = 3'd1;  // wait for request, refusals branch
  localparam logic [2:0] C_FOUND = 3'd2;  // used block branches back, else emit
  localparam logic [2:0] C_EMIT  = 3'd3;  // branch once the output slot frees
  localparam logic [2:0] C_JUMP  = 3'd4;  // unconditional

  // remainder unit controls
  typedef struct packed {
    logic load;
    logic step;
  } iba_rem_ctl_t;

  // one control word of the sequencer
  typedef struct packed {
    logic            accept;
    logic            lfsr_step;
    iba_rem_ctl_t    rem;
    logic            mem_rd;
    logic            claim;
    logic            refuse;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } iba_uword_t;

  // microcode table
  function automatic iba_uword_t iba_ucode(input logic [PC_W-1:0] pc);
    iba_uword_t w;
    w = '0;
    case (pc)
      PC_IDLE: begin
        w.accept = 1'b1;
        w.cond   = C_START;
        w.target = PC_REFUSE;
      end
      PC_PICK: begin
        w.lfsr_step = 1'b1;
        w.rem.load  = 1'b1;
        w.cond      = C_NEXT;
      end
      PC_MOD_HI: begin
        w.rem.step = 1'b1;
        w.cond     = C_NEXT;
      end
      PC_MOD_LO: begin
        w.rem.step = 1'b1;
        w.mem_rd   = 1'b1;
        w.cond     = C_NEXT;
      end
      PC_CHECK: begin
        w.claim  = 1'b1;
        w.cond   = C_FOUND;
        w.target = PC_PICK;
      end
      PC_REFUSE: begin
        w.refuse = 1'b1;
        w.cond   = C_EMIT;
        w.target = PC_IDLE;
      end
      default: begin
        w.cond   = C_JUMP;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== design/iba_rem_unit.sv =====
// iba_rem_unit: iterative remainder of the 16-bit candidate by the block total,
// eight dividend bits per step
// depends on iba_pkg
module iba_rem_unit
  import iba_pkg::*;
(
  input  logic               clk,
  input  iba_rem_ctl_t       ctl,
  input  logic [LFSR_W-1:0]  dividend,
  input  logic [TOTAL_W-1:0] divisor,
  output logic [TOTAL_W-1:0] rem_q,
  output logic [TOTAL_W-1:0] rem_nxt
);

  logic [LFSR_W-1:0]  dvd_r;
  logic [TOTAL_W-1:0] rem_r;

  // restoring remainder over the top byte of the dividend
  always_comb begin
    logic [TOTAL_W:0]   t;
    logic [TOTAL_W-1:0] r;
    r = rem_r;
    t = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {r, dvd_r[LFSR_W-1-i]};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      r = t[TOTAL_W-1:0];
    end
    rem_nxt = r;
  end

  // dividend shift and partial remainder
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (ctl.step) begin
      dvd_r <= dvd_r << STEP_BITS;
      rem_r <= rem_nxt;
    end
  end

  assign rem_q = rem_r;

endmodule

// ===== design/indexed_block_allocator_unit.sv =====
// Indexed block allocator. A request for N data blocks (0..MAX_FILE_BLOCKS) is
// taken in the idle step and answered with the index block then N data blocks,
// the final word marked last, or with one refusal word when N exceeds
// MAX_FILE_BLOCKS or N+1 exceeds the free count. Blocks are drawn from a 16-bit
// LFSR modulo the device total; each draw runs the LFSR step, two 8-bit
// remainder steps that end in the free map read, and the check, and a draw that
// hits a used block is repeated; a claim and a refusal wait while the result
// channel stalls. After reset and after each write of the total register the
// free map is swept clear, during which no request is accepted.
// depends on iba_pkg and iba_rem_unit
module indexed_block_allocator_unit
  import iba_pkg::*;
#(
  parameter int MAX_BLOCKS      = 128,
  parameter int MAX_FILE_BLOCKS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [REQ_W-1:0]  in_data_block_count,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BLK_W-1:0]  out_block_number,
  output logic              out_is_index_block,
  output logic              out_status,
  output logic              out_last,
  // configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [SEED_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_FILE_BLOCKS + 1);
  localparam logic [AW-1:0] LastAddr = AW'(MAX_BLOCKS - 1);
  localparam logic [5:0] MaxFile = 6'(MAX_FILE_BLOCKS);
  localparam logic [TOTAL_W-1:0] ResetTotal =
    (MAX_BLOCKS < 128) ? TOTAL_W'(MAX_BLOCKS) : TOTAL_W'(128);

  // control state
  logic [PC_W-1:0]    pc_r, pc_nxt;
  logic               clear_active_r;
  logic [AW-1:0]      clr_addr_r;
  logic [TOTAL_W-1:0] total_r;
  logic [LFSR_W-1:0]  lfsr_r, lfsr_nxt;
  logic [TOTAL_W-1:0] blocks_left_r;
  logic               out_valid_r;

  // request and result payload
  logic [CW-1:0]      rem_cnt_r;
  logic               first_r;
  logic [BLK_W-1:0]   out_block_number_r;
  logic               out_is_index_block_r;
  logic               out_status_r;
  logic               out_last_r;
  logic               rd_used_r;

  // free map, one used bit per block
  logic               used_mem [MAX_BLOCKS];

  iba_uword_t         uw;
  logic               in_accept;
  logic               cfg_we;
  logic               refuse_req;
  logic               out_slot;
  logic               emit_ok;
  logic               refuse_ok;
  logic [TOTAL_W-1:0] cfg_total;
  logic [LFSR_W-1:0]  cfg_seed;
  logic [TOTAL_W-1:0] rem_q;
  logic [TOTAL_W-1:0] rem_nxt;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;

  // remainder unit for candidate selection
  iba_rem_unit u_rem (
    .clk      (clk),
    .ctl      (uw.rem),
    .dividend (lfsr_nxt),
    .divisor  (total_r),
    .rem_q    (rem_q),
    .rem_nxt  (rem_nxt)
  );

  // control word fetch and handshakes
  assign uw        = iba_ucode(pc_r);
  assign in_stall  = !(uw.accept && !clear_active_r);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign out_slot  = !out_valid_r || !out_stall;
  assign emit_ok   = uw.claim && !rd_used_r && out_slot;
  assign refuse_ok = uw.refuse && out_slot;

  // refusal test on the incoming request
  assign refuse_req = ({1'b0, in_data_block_count} > MaxFile) ||
                      (({3'b0, in_data_block_count} + 8'd1) > blocks_left_r);

  // configuration value cleanup
  always_comb begin
    cfg_total = cfg_data[TOTAL_W-1:0];
    if (cfg_total == '0) begin
      cfg_total = TOTAL_W'(1);
    end else if (int'(cfg_total) > MAX_BLOCKS) begin
      cfg_total = TOTAL_W'(MAX_BLOCKS);
    end
    cfg_seed = (cfg_data == '0) ? LFSR_W'(1) : cfg_data;
  end

  // galois lfsr step
  assign lfsr_nxt = {1'b0, lfsr_r[LFSR_W-1:1]} ^ (lfsr_r[0] ? LFSR_TAPS : '0);

  // next step of the sequencer
  always_comb begin
    pc_nxt = pc_r;
    case (uw.cond)
      C_NEXT:  pc_nxt = pc_r + PC_W'(1);
      C_START: begin
        if (in_accept) begin
          pc_nxt = refuse_req ? uw.target : pc_r + PC_W'(1);
        end
      end
      C_FOUND: begin
        if (rd_used_r) begin
          pc_nxt = uw.target;
        end else if (out_slot) begin
          pc_nxt = (rem_cnt_r == '0) ? PC_IDLE : uw.target;
        end
      end
      C_EMIT:  pc_nxt = out_slot ? uw.target : pc_r;
      C_JUMP:  pc_nxt = uw.target;
      default: pc_nxt = PC_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r           <= PC_IDLE;
      clear_active_r <= 1'b1;
      clr_addr_r     <= '0;
      total_r        <= ResetTotal;
      lfsr_r         <= LFSR_W'(1);
      blocks_left_r  <= ResetTotal;
      out_valid_r    <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      // clearing sweep of the free map
      if (clear_active_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == LastAddr) begin
          clear_active_r <= 1'b0;
        end
      end
      if (uw.lfsr_step) begin
        lfsr_r <= lfsr_nxt;
      end
      if (emit_ok) begin
        blocks_left_r <= blocks_left_r - TOTAL_W'(1);
      end
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_TOTAL: begin
            total_r        <= cfg_total;
            blocks_left_r  <= cfg_total;
            clear_active_r <= 1'b1;
            clr_addr_r     <= '0;
          end
          CFG_SEED: lfsr_r <= cfg_seed;
          default: ;
        endcase
      end
      // output register
      if (emit_ok || refuse_ok) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request bookkeeping and result words
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rem_cnt_r <= CW'(in_data_block_count);
      first_r   <= 1'b1;
    end else if (emit_ok) begin
      rem_cnt_r <= rem_cnt_r - CW'(1);
      first_r   <= 1'b0;
    end
    if (emit_ok) begin
      out_block_number_r   <= rem_q[BLK_W-1:0];
      out_is_index_block_r <= first_r;
      out_status_r         <= ST_ALLOCATED;
      out_last_r           <= (rem_cnt_r == '0);
    end else if (refuse_ok) begin
      out_block_number_r   <= '0;
      out_is_index_block_r <= 1'b0;
      out_status_r         <= ST_REFUSED;
      out_last_r           <= 1'b1;
    end
  end

  // free map port
  assign mem_we    = clear_active_r || emit_ok;
  assign mem_waddr = clear_active_r ? clr_addr_r : AW'(rem_q);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      used_mem[mem_waddr] <= !clear_active_r;
    end
    if (uw.mem_rd) begin
      rd_used_r <= used_mem[AW'(rem_nxt)];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_block_number   = out_block_number_r;
  assign out_is_index_block = out_is_index_block_r;
  assign out_status         = out_status_r;
  assign out_last           = out_last_r;

`ifndef SYNTHESIS
  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !((emit_ok || refuse_ok) && out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  // a claim always has a free block to take
  a_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
    emit_ok |-> (blocks_left_r != '0))
    else $error("free count underflow");

  // claimed block lies on the device
  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    emit_ok |-> (rem_q < total_r))
    else $error("claimed block beyond total");

  // an accepted request leaves the idle step
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (pc_r != PC_IDLE))
    else $error("request accepted but sequencer idle");
`endif

endmodule
